// File: rtl/core/mtd_pkg.sv
package mtd_pkg;

   // Fixed field widths.
   localparam int MAG_W   = 17;
   localparam int SPEED_W = 21;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 17;
   localparam int CSR_IDX_W = 3;

   // One g in Q14.
   localparam logic signed [16:0] ONE_G = 17'sd16384;

   // Square root of a 34 bit radicand, two bits per step.
   localparam int ROOT_STEPS = 17;

   // Depth of the queue between front and back (a power of two).
   localparam int QUEUE_DEPTH = 2;

   // Smoothing weights, sum 256.
   localparam logic [7:0] OLD_WEIGHT = 8'd179;
   localparam logic [7:0] NEW_WEIGHT = 8'd77;

   localparam logic [1:0] POSTURE_UPRIGHT  = 2'd0;
   localparam logic [1:0] POSTURE_FORWARD  = 2'd1;
   localparam logic [1:0] POSTURE_BACKWARD = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MOTION_TRIP      = 3'd0,
      REG_NOISE_FLOOR      = 3'd1,
      REG_STOP_TIMEOUT_MS  = 3'd2,
      REG_SPEED_SCALE      = 3'd3,
      REG_FORWARD_TANGENT  = 3'd4,
      REG_BACKWARD_TANGENT = 3'd5
   } reg_index_type;

   localparam logic [16:0] RST_MOTION_TRIP      = 17'd1966;
   localparam logic [16:0] RST_NOISE_FLOOR      = 17'd492;
   localparam logic [15:0] RST_STOP_TIMEOUT_MS  = 16'd1200;
   localparam logic [7:0]  RST_SPEED_SCALE      = 8'd152;
   localparam logic [15:0] RST_FORWARD_TANGENT  = 16'd11556;
   localparam logic [15:0] RST_BACKWARD_TANGENT = 16'd11556;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [TIME_W-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]         posture;
      logic               moving;
      logic [MAG_W-1:0]   motion_level;
      logic [SPEED_W-1:0] smooth_speed;
   } rsp_type;

   typedef struct packed {
      logic [16:0] motion_trip;
      logic [16:0] noise_floor;
      logic [15:0] stop_timeout_ms;
      logic [7:0]  speed_scale;
      logic [15:0] forward_tangent;
      logic [15:0] backward_tangent;
   } cfg_type;

   // One classified sample handed from the front to the back.
   typedef struct packed {
      logic [1:0]        posture;
      logic [MAG_W-1:0]  mag;
      logic [TIME_W-1:0] time_ms;
   } entry_type;

endpackage

// File: rtl/core/mtd_front.sv
module mtd_front (
   input  logic               clock,
   input  logic               reset,
   input  mtd_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  mtd_pkg::req_type   req_data,
   output logic               push,
   output mtd_pkg::entry_type push_entry,
   input  logic               queue_full
);
   import mtd_pkg::*;

   localparam int STEP_W = $clog2(ROOT_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_STEPS - 1);

   typedef enum logic [2:0] {
      F_IDLE,
      F_SQUARE,
      F_SUM,
      F_ROOT,
      F_PUSH
   } fstate_type;

   fstate_type        state_ff, state_in;
   req_type           sample_ff, sample_in;
   logic [30:0]       x2_ff, x2_in, y2_ff, y2_in, z2_ff, z2_in;
   logic [31:0]       lz2_ff, lz2_in, t2_ff, t2_in, h2_ff, h2_in;
   logic [63:0]       prod_ff, prod_in;
   logic [33:0]       rad_ff, rad_in;
   logic [19:0]       rem_ff, rem_in;
   logic [MAG_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic signed [31:0] x_sq, y_sq, z_sq;
   logic signed [16:0] lz;
   logic signed [33:0] lz_sq;
   logic [15:0]        tangent;
   logic [21:0]        rem_shift, trial;
   logic               y_pos, y_neg, lean;
   logic [MAG_W-1:0]   mag;

   always_comb begin
      x_sq  = sample_ff.accel_x * sample_ff.accel_x;
      y_sq  = sample_ff.accel_y * sample_ff.accel_y;
      z_sq  = sample_ff.accel_z * sample_ff.accel_z;
      lz    = 17'(signed'(sample_ff.accel_z)) - ONE_G;
      lz_sq = lz * lz;
      y_pos = !sample_ff.accel_y[15] && (sample_ff.accel_y != 16'sd0);
      y_neg = sample_ff.accel_y[15];
      tangent = y_pos ? cfg.forward_tangent : cfg.backward_tangent;

      // One step of the digit-by-digit root: bring down two bits, try 4r+1.
      rem_shift = {rem_ff, rad_ff[33:32]};
      trial     = {3'b000, root_ff, 2'b01};

      lean = {1'b0, y2_ff, 32'd0} > prod_ff;
      mag  = (root_ff < cfg.noise_floor) ? '0 : root_ff;
      push_entry.posture = !lean ? POSTURE_UPRIGHT :
                           y_pos ? POSTURE_FORWARD :
                           y_neg ? POSTURE_BACKWARD : POSTURE_UPRIGHT;
      push_entry.mag     = mag;
      push_entry.time_ms = sample_ff.time_ms;

      state_in  = state_ff;
      sample_in = sample_ff;
      x2_in     = x2_ff;
      y2_in     = y2_ff;
      z2_in     = z2_ff;
      lz2_in    = lz2_ff;
      t2_in     = t2_ff;
      h2_in     = h2_ff;
      prod_in   = t2_ff * h2_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      push      = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               sample_in = req_data;
               state_in  = F_SQUARE;
            end
         end
         F_SQUARE: begin
            x2_in    = x_sq[30:0];
            y2_in    = y_sq[30:0];
            z2_in    = z_sq[30:0];
            lz2_in   = lz_sq[31:0];
            t2_in    = tangent * tangent;
            state_in = F_SUM;
         end
         F_SUM: begin
            h2_in    = 32'(x2_ff) + 32'(z2_ff);
            rad_in   = 34'(x2_ff) + 34'(y2_ff) + 34'(lz2_ff);
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = F_ROOT;
         end
         F_ROOT: begin
            if (rem_shift >= trial) begin
               rem_in  = 20'(rem_shift - trial);
               root_in = {root_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[19:0];
               root_in = {root_ff[MAG_W-2:0], 1'b0};
            end
            rad_in  = {rad_ff[31:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign req_stall = (state_ff != F_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sample_ff <= sample_in;
      x2_ff     <= x2_in;
      y2_ff     <= y2_in;
      z2_ff     <= z2_in;
      lz2_ff    <= lz2_in;
      t2_ff     <= t2_in;
      h2_ff     <= h2_in;
      prod_ff   <= prod_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      step_ff   <= step_in;
   end

endmodule

// File: rtl/core/mtd_fifo.sv
module mtd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mtd_pkg::entry_type head_entry
);
   import mtd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/mtd_back.sv
module mtd_back (
   input  logic               clock,
   input  logic               reset,
   input  mtd_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  mtd_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mtd_pkg::rsp_type   rsp_data
);
   import mtd_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE,
      B_UPDATE,
      B_SCALE,
      B_WEIGH,
      B_DONE
   } bstate_type;

   bstate_type         state_ff, state_in;
   entry_type          entry_ff, entry_in;
   logic [MAG_W-1:0]   held_ff, held_in;
   logic               flag_ff, flag_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [SPEED_W-1:0] filt_ff, filt_in;
   logic [SPEED_W-1:0] raw_ff, raw_in;
   logic [28:0]        old_part_ff, old_part_in, new_part_ff, new_part_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]  elapsed;
   logic [24:0]        scaled;
   logic [29:0]        mix;
   logic [SPEED_W-1:0] smooth;
   logic               slot_free;

   always_comb begin
      elapsed   = entry_ff.time_ms - last_ff;
      scaled    = held_ff * cfg.speed_scale;
      mix       = 30'(old_part_ff) + 30'(new_part_ff);
      smooth    = mix[28:8];
      slot_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      entry_in     = entry_ff;
      held_in      = held_ff;
      flag_in      = flag_ff;
      last_in      = last_ff;
      filt_in      = filt_ff;
      raw_in       = raw_ff;
      old_part_in  = old_part_ff;
      new_part_in  = new_part_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               entry_in = head_entry;
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            if (entry_ff.mag > cfg.motion_trip) begin
               held_in = entry_ff.mag;
               last_in = entry_ff.time_ms;
               flag_in = 1'b1;
            end else if (elapsed > TIME_W'(cfg.stop_timeout_ms)) begin
               held_in = '0;
               flag_in = 1'b0;
            end
            state_in = B_SCALE;
         end
         B_SCALE: begin
            raw_in   = flag_ff ? scaled[24:4] : '0;
            state_in = B_WEIGH;
         end
         B_WEIGH: begin
            old_part_in = filt_ff * OLD_WEIGHT;
            new_part_in = raw_ff * NEW_WEIGHT;
            state_in    = B_DONE;
         end
         B_DONE: begin
            if (slot_free) begin
               filt_in                  = smooth;
               rsp_valid_in             = 1'b1;
               rsp_data_in.posture      = entry_ff.posture;
               rsp_data_in.moving       = flag_ff;
               rsp_data_in.motion_level = held_ff;
               rsp_data_in.smooth_speed = smooth;
               state_in                 = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         held_ff      <= '0;
         flag_ff      <= 1'b0;
         last_ff      <= '0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         flag_ff      <= flag_in;
         last_ff      <= last_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      entry_ff    <= entry_in;
      raw_ff      <= raw_in;
      old_part_ff <= old_part_in;
      new_part_ff <= new_part_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/core/motion_tilt_detector_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_data  (accel x/y/z, time_ms)
// rsp       out        rsp_valid/rsp_stall  rsp_data  (posture, moving, level, speed)
// csr       in         csr_we               csr_index, csr_wdata
//
// The front takes one beat at a time and stalls its input while busy: one
// accept state, one of squares, one of sums, the two-bits-per-step square
// root, then one state to enter the queue. The back works on one beat at a time.
// Reset is synchronous; it restores the register defaults and clears the
// motion state and the filtered speed. A stalled response only backs up the
// two-entry queue; the front keeps working until the queue is full.
module motion_tilt_detector_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mtd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mtd_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [mtd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mtd_pkg::CSR_W-1:0]      csr_wdata
);
   import mtd_pkg::*;

   // Configuration registers, read live by both halves without a shadow copy.
   // The user writes only while the block is idle; the block does not enforce it.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MOTION_TRIP:      cfg_in.motion_trip      = csr_wdata[16:0];
            REG_NOISE_FLOOR:      cfg_in.noise_floor      = csr_wdata[16:0];
            REG_STOP_TIMEOUT_MS:  cfg_in.stop_timeout_ms  = csr_wdata[15:0];
            REG_SPEED_SCALE:      cfg_in.speed_scale      = csr_wdata[7:0];
            REG_FORWARD_TANGENT:  cfg_in.forward_tangent  = csr_wdata[15:0];
            REG_BACKWARD_TANGENT: cfg_in.backward_tangent = csr_wdata[15:0];
            // Indexes past the last register are dropped.
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_trip      <= RST_MOTION_TRIP;
         cfg_ff.noise_floor      <= RST_NOISE_FLOOR;
         cfg_ff.stop_timeout_ms  <= RST_STOP_TIMEOUT_MS;
         cfg_ff.speed_scale      <= RST_SPEED_SCALE;
         cfg_ff.forward_tangent  <= RST_FORWARD_TANGENT;
         cfg_ff.backward_tangent <= RST_BACKWARD_TANGENT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front classifies each sample: posture from the squared tangent
   // compare and the motion magnitude from the square root, with the noise
   // floor already applied.
   logic      push, queue_full, head_valid, pop;
   entry_type push_entry, head_entry;

   mtd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // A short queue decouples the two halves so that a stalled response does
   // not hold up the square root of the next sample.
   mtd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The back owns the motion state: threshold and timeout update, speed
   // scaling, the low-pass filter and the output register.
   mtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: sim/motion_tilt_detector_core_tb.sv
module motion_tilt_detector_core_tb;
   import mtd_pkg::*;

   // The quiet stretch after the last result leaves the core idle for a register write.
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_TIME = 4_000_000;
   localparam int MAX_REPORTS = 10;

   // One g in Q14 counts, used to take gravity out of the Z axis.
   localparam longint GRAVITY_Q14 = 16384;

   // Weights of the speed low-pass filter; they add up to 256.
   localparam longint SMOOTH_OLD = 179;
   localparam longint SMOOTH_NEW = 77;
   localparam logic [63:0] SPEED_CEILING = (64'd1 << SPEED_W) - 64'd1;

   // Register indexes the core does not decode. Writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Idle rates of the two sides, in percent of cycles.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // A nonzero value makes the receiver refuse results for that many cycles.
   int hold_cycles = 0;
   int error_count = 0;

   // Our own copy of the registers and of the motion state of the core.
   cfg_type     model_cfg;
   logic [16:0] held_level;
   logic        moving_flag;
   logic [31:0] last_motion_ms;
   logic [20:0] filtered_speed;

   // Timestamp of the random sample stream.
   logic [31:0] sample_clock_ms = '0;

   // Predicted result beats, oldest first.
   rsp_type expected_readings[$];

   motion_tilt_detector_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor square root, one result bit per step from the top down. The
   // radicand stays below 2^34, so the root always fits in 17 bits.
   function automatic logic [16:0] root_floor(input logic [63:0] radicand);
      logic [16:0] root;
      logic [16:0] trial;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (17'd1 << b);
         if (64'(trial) * 64'(trial) <= radicand)
            root = trial;
      end
      return root;
   endfunction

   // Advances the motion state by one accepted sample and returns the beat
   // that the core must produce for it.
   function automatic rsp_type track_motion(input req_type s);
      longint      x;
      longint      y;
      longint      z;
      longint      lz;
      logic [63:0] x2;
      logic [63:0] y2;
      logic [63:0] z2;
      logic [63:0] lz2;
      logic [63:0] horiz2;
      logic [63:0] lean2;
      logic [63:0] limit2;
      logic [63:0] raw_speed;
      logic [63:0] smoothed;
      logic [16:0] mag;
      logic [31:0] elapsed;
      rsp_type     beat;

      x = $signed(s.accel_x);
      y = $signed(s.accel_y);
      z = $signed(s.accel_z);
      lz = z - GRAVITY_Q14;
      x2 = x * x;
      y2 = y * y;
      z2 = z * z;
      lz2 = lz * lz;

      // Posture compares squared tangents, so a lean with no horizontal
      // component always counts and y = 0 is always upright.
      horiz2 = x2 + z2;
      lean2 = y2 << 32;
      beat.posture = POSTURE_UPRIGHT;
      if (y > 0) begin
         limit2 = 64'(model_cfg.forward_tangent) * 64'(model_cfg.forward_tangent);
         if (lean2 > limit2 * horiz2)
            beat.posture = POSTURE_FORWARD;
      end else if (y < 0) begin
         limit2 = 64'(model_cfg.backward_tangent) * 64'(model_cfg.backward_tangent);
         if (lean2 > limit2 * horiz2)
            beat.posture = POSTURE_BACKWARD;
      end

      mag = root_floor(x2 + y2 + lz2);
      if (mag < model_cfg.noise_floor)
         mag = '0;

      // The timeout uses a wrapping difference, so a timestamp that goes
      // backward looks like a very long quiet stretch.
      elapsed = s.time_ms - last_motion_ms;
      if (mag > model_cfg.motion_trip) begin
         held_level = mag;
         last_motion_ms = s.time_ms;
         moving_flag = 1'b1;
      end else if (elapsed > 32'(model_cfg.stop_timeout_ms)) begin
         moving_flag = 1'b0;
         held_level = '0;
      end

      raw_speed = moving_flag ? (64'(held_level) * 64'(model_cfg.speed_scale)) >> 4 : 64'd0;
      smoothed = (SMOOTH_OLD * 64'(filtered_speed) + SMOOTH_NEW * raw_speed) >> 8;
      if (smoothed > SPEED_CEILING)
         smoothed = SPEED_CEILING;
      filtered_speed = smoothed[20:0];

      beat.moving = moving_flag;
      beat.motion_level = held_level;
      beat.smooth_speed = filtered_speed;
      return beat;
   endfunction

   function automatic req_type pack_sample(input int x, input int y, input int z,
                                           input logic [31:0] stamp);
      req_type s;
      s.accel_x = 16'(x);
      s.accel_y = 16'(y);
      s.accel_z = 16'(z);
      s.time_ms = stamp;
      return s;
   endfunction

   // Draws one sample of the random stream. Most samples sit near rest or in
   // moderate motion so that posture, noise and threshold decisions all come
   // up often; the rest cover the whole range and the degenerate axes.
   function automatic req_type next_sample();
      int kind;
      int step_kind;
      int sel;
      int x;
      int y;
      int z;

      kind = $urandom_range(99);
      step_kind = $urandom_range(99);
      if (step_kind < 85)
         sample_clock_ms += $urandom_range(300);
      else if (step_kind < 95)
         sample_clock_ms += $urandom_range(3000, 1000);
      else
         sample_clock_ms = $urandom;

      if (kind < 40) begin
         x = int'($urandom_range(1200)) - 600;
         y = int'($urandom_range(12000)) - 6000;
         z = 16384 + int'($urandom_range(1200)) - 600;
      end else if (kind < 75) begin
         x = int'($urandom_range(16000)) - 8000;
         y = int'($urandom_range(16000)) - 8000;
         z = 16384 + int'($urandom_range(16000)) - 8000;
      end else if (kind < 90) begin
         x = int'($urandom_range(65535)) - 32768;
         y = int'($urandom_range(65535)) - 32768;
         z = int'($urandom_range(65535)) - 32768;
      end else begin
         sel = $urandom_range(3);
         x = int'($urandom_range(65535)) - 32768;
         y = int'($urandom_range(65535)) - 32768;
         z = int'($urandom_range(65535)) - 32768;
         case (sel)
            0: begin
               x = 0;
               z = 0;
            end
            1: y = 0;
            2: begin
               x = $urandom_range(1) ? 32767 : -32768;
               y = $urandom_range(1) ? 32767 : -32768;
               z = $urandom_range(1) ? 32767 : -32768;
            end
            default: begin
               x = 0;
               y = 0;
               z = 16384;
            end
         endcase
      end
      return pack_sample(x, y, z, sample_clock_ms);
   endfunction

   // Offers one beat, holds it until the core takes it, and records what the
   // core must answer. Returns right after the accepting clock edge.
   task automatic offer_sample(input req_type s);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_readings.push_back(track_motion(s));
   endtask

   // Stops offering beats and waits until every predicted beat has come back
   // and the core has had time to go quiet.
   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes one register; called at a falling edge while the core is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         REG_MOTION_TRIP:      model_cfg.motion_trip = value;
         REG_NOISE_FLOOR:      model_cfg.noise_floor = value;
         REG_STOP_TIMEOUT_MS:  model_cfg.stop_timeout_ms = value[15:0];
         REG_SPEED_SCALE:      model_cfg.speed_scale = value[7:0];
         REG_FORWARD_TANGENT:  model_cfg.forward_tangent = value[15:0];
         REG_BACKWARD_TANGENT: model_cfg.backward_tangent = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all_regs(input logic [16:0] threshold, input logic [16:0] noise,
                                 input logic [15:0] timeout, input logic [7:0] gain,
                                 input logic [15:0] fwd_tan, input logic [15:0] bwd_tan);
      write_reg(REG_MOTION_TRIP, threshold);
      write_reg(REG_NOISE_FLOOR, noise);
      write_reg(REG_STOP_TIMEOUT_MS, 17'(timeout));
      write_reg(REG_SPEED_SCALE, 17'(gain));
      write_reg(REG_FORWARD_TANGENT, 17'(fwd_tan));
      write_reg(REG_BACKWARD_TANGENT, 17'(bwd_tan));
   endtask

   task automatic restore_defaults();
      write_all_regs(RST_MOTION_TRIP, RST_NOISE_FLOOR, RST_STOP_TIMEOUT_MS,
                     RST_SPEED_SCALE, RST_FORWARD_TANGENT, RST_BACKWARD_TANGENT);
   endtask

   // Reset settings: rest, the axis extremes, leans with no horizontal part,
   // the noise and motion edges, the timeout edge, a wrapping timestamp, a
   // timestamp that runs backward and the exact tangent boundary.
   task automatic run_directed_extremes();
      offer_sample(pack_sample(0, 0, 16384, 32'd0));
      offer_sample(pack_sample(32767, 32767, 32767, 32'd10));
      offer_sample(pack_sample(-32768, -32768, -32768, 32'd20));
      offer_sample(pack_sample(0, 16384, 0, 32'd30));
      offer_sample(pack_sample(0, -16384, 0, 32'd40));
      offer_sample(pack_sample(0, 0, 0, 32'd50));
      offer_sample(pack_sample(100, 0, 16384, 32'd60));
      offer_sample(pack_sample(492, 0, 16384, 32'd70));
      offer_sample(pack_sample(1966, 0, 16384, 32'd80));
      offer_sample(pack_sample(1967, 0, 16384, 32'd90));
      // Exactly the timeout after the last motion keeps moving; one more clears it.
      offer_sample(pack_sample(0, 0, 16384, 32'd1290));
      offer_sample(pack_sample(0, 0, 16384, 32'd1291));
      offer_sample(pack_sample(3000, 0, 16384, 32'hFFFF_FF00));
      offer_sample(pack_sample(0, 0, 16384, 32'h0000_0100));
      offer_sample(pack_sample(0, 0, 16384, 32'h0000_0400));
      offer_sample(pack_sample(3000, 2000, 16384, 32'h0000_0500));
      offer_sample(pack_sample(0, 0, 16384, 32'h0000_04FF));
      // With the reset tangent, y = 2889 over z = 16384 is exactly on the limit.
      offer_sample(pack_sample(0, 2889, 16384, 32'h0000_0600));
      offer_sample(pack_sample(0, 2890, 16384, 32'h0000_0610));
      offer_sample(pack_sample(0, -2889, 16384, 32'h0000_0620));
      offer_sample(pack_sample(0, -2890, 16384, 32'h0000_0630));
      wait_drain();
   endtask

   // Zero tangents make any lean count, full tangents almost none. The first
   // writes carry bit 16, which a 16 bit register must drop, and the spare
   // indexes must leave everything alone.
   task automatic run_tangent_limits();
      write_reg(REG_FORWARD_TANGENT, 17'h1_0000);
      write_reg(REG_BACKWARD_TANGENT, 17'h1_0000);
      write_reg(SPARE_INDEX_LO, 17'h1_FFFF);
      write_reg(SPARE_INDEX_HI, 17'h0_0000);
      offer_sample(pack_sample(5000, 1, 16384, 32'd5000));
      offer_sample(pack_sample(5000, -1, 16384, 32'd5010));
      offer_sample(pack_sample(5000, 0, 16384, 32'd5020));
      wait_drain();
      write_reg(REG_FORWARD_TANGENT, 17'h1_FFFF);
      write_reg(REG_BACKWARD_TANGENT, 17'h1_FFFF);
      write_reg(SPARE_INDEX_HI, 17'h1_FFFF);
      offer_sample(pack_sample(1, 32767, 0, 32'd5030));
      offer_sample(pack_sample(0, -32768, 1, 32'd5040));
      offer_sample(pack_sample(32767, 32767, 32767, 32'd5050));
      wait_drain();
      restore_defaults();
   endtask

   // Register extremes, then trip and floor above any magnitude; a random burst each.
   task automatic run_config_extremes();
      write_all_regs(17'd0, 17'd0, 16'd0, 8'd255, 16'd0, 16'hFFFF);
      repeat (10) offer_sample(next_sample());
      wait_drain();
      write_all_regs(17'h1_FFFF, 17'h1_FFFF, 16'hFFFF, 8'd0, 16'hFFFF, 16'd0);
      repeat (10) offer_sample(next_sample());
      wait_drain();
      write_all_regs(17'd67600, 17'd67600, 16'd1200, 8'd16, 16'd11556, 16'd11556);
      repeat (10) offer_sample(next_sample());
      wait_drain();
      restore_defaults();
   endtask

   task automatic randomize_config();
      write_all_regs(17'($urandom_range(6000)), 17'($urandom_range(2500)),
                     16'($urandom_range(2500)), 8'($urandom_range(255)),
                     16'($urandom_range(40000)), 16'($urandom_range(40000)));
   endtask

   // A random stream with fresh register settings every 80 beats.
   task automatic run_random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 80 == 0) begin
            wait_drain();
            randomize_config();
         end
         offer_sample(next_sample());
      end
      wait_drain();
   endtask

   // The receiver refuses results for a long stretch while beats keep coming,
   // so the queue fills and the core must stall its input.
   task automatic run_backpressure();
      hold_cycles = 400;
      repeat (16) offer_sample(next_sample());
      wait_drain();
   endtask

   // The receiver side changes its stall at the falling edge, either from the
   // random idle rate or from a pending hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Every accepted result beat is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result beat: posture %0d moving %0d level %0d speed %0d",
                        rsp_data.posture, rsp_data.moving, rsp_data.motion_level,
                        rsp_data.smooth_speed);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_data.posture !== want.posture || rsp_data.moving !== want.moving ||
                rsp_data.motion_level !== want.motion_level ||
                rsp_data.smooth_speed !== want.smooth_speed) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"result mismatch (expected/actual): posture %0d/%0d ",
                            "moving %0d/%0d level %0d/%0d speed %0d/%0d"},
                           want.posture, rsp_data.posture, want.moving, rsp_data.moving,
                           want.motion_level, rsp_data.motion_level,
                           want.smooth_speed, rsp_data.smooth_speed);
            end
         end
      end
   end

   initial begin : main_sequence
      int waited;
      model_cfg = '{motion_trip: RST_MOTION_TRIP, noise_floor: RST_NOISE_FLOOR,
                    stop_timeout_ms: RST_STOP_TIMEOUT_MS, speed_scale: RST_SPEED_SCALE,
                    forward_tangent: RST_FORWARD_TANGENT,
                    backward_tangent: RST_BACKWARD_TANGENT};
      held_level = '0;
      moving_flag = 1'b0;
      last_motion_ms = '0;
      filtered_speed = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The sender idles less than the receiver first, then the other way
      // round, then neither idles.
      send_idle_pct = 22;
      recv_idle_pct = 52;
      run_directed_extremes();
      run_tangent_limits();
      run_config_extremes();
      run_random_phase(320);
      send_idle_pct = 52;
      recv_idle_pct = 22;
      run_random_phase(320);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(320);
      run_backpressure();

      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (expected_readings.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_readings.size() != 0) begin
         $display("%0d predicted result beats never arrived", expected_readings.size());
         error_count += expected_readings.size();
      end

      if (error_count == 0)
         $display("motion_tilt_detector_core_tb: clean");
      else
         $display("motion_tilt_detector_core_tb: errors");
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #(WATCHDOG_TIME);
      $display("motion_tilt_detector_core_tb: errors");
      $finish;
   end

endmodule

// File: files.f
rtl/core/mtd_pkg.sv
rtl/core/mtd_front.sv
rtl/core/mtd_fifo.sv
rtl/core/mtd_back.sv
rtl/core/motion_tilt_detector_core.sv
sim/motion_tilt_detector_core_tb.sv
